// File: rtl/ptb_pkg.sv
// Package for the pausable timer bank: command codes, command classes and
// the command and result beat layouts. Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

	localparam logic [3:0] FN_TICK    = 4'd0;
	localparam logic [3:0] FN_ADD     = 4'd1;
	localparam logic [3:0] FN_REMOVE  = 4'd2;
	localparam logic [3:0] FN_START   = 4'd3;
	localparam logic [3:0] FN_STOP    = 4'd4;
	localparam logic [3:0] FN_PAUSE   = 4'd5;
	localparam logic [3:0] FN_RESUME  = 4'd6;
	localparam logic [3:0] FN_RESET   = 4'd7;
	localparam logic [3:0] FN_SET_DUR = 4'd8;
	localparam logic [3:0] FN_SET_NFY = 4'd9;
	localparam logic [3:0] FN_QUERY   = 4'd10;
	localparam logic [3:0] FN_CLEAR   = 4'd11;

	typedef enum logic [2:0] {
		C_TICK,
		C_ADD,
		C_SLOT,
		C_CLEAR,
		C_BAD
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [3:0]  func;
		logic [3:0]  slot;
		logic [31:0] duration;
		logic        notify;
		logic        self_remove;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic        ok;
		logic [3:0]  timer_index;
		logic        exists;
		logic        running;
		logic        finished;
		logic [31:0] elapsed;
		logic [31:0] remaining;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/ptb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/ptb_front.sv
// Front end of the timer bank: classify incoming commands and hold them in
// a two-entry queue for the executor. Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptb_front import ptb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [3:0]  func,
	input  wire logic [3:0]  slot,
	input  wire logic [31:0] duration,
	input  wire logic        notify,
	input  wire logic        self_remove,
	output logic             cmd_valid,
	input  wire logic        cmd_pop,
	output cmd_t             cmd
);
	cmd_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cls_t       cls;
	cmd_t       din;

	always_comb begin
		unique case (func) inside
			FN_TICK:  cls = C_TICK;
			FN_ADD:   cls = C_ADD;
			FN_CLEAR: cls = C_CLEAR;
			[FN_REMOVE:FN_QUERY]: cls = C_SLOT;
			default:  cls = C_BAD;
		endcase
		din = '{cls: cls, func: func, slot: slot, duration: duration,
			notify: notify, self_remove: self_remove};
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				ent_q[wr_q] <= din;
				wr_q        <= !wr_q;
			end
			if (cmd_pop && cmd_valid)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((cmd_pop && cmd_valid) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ptb_resq.sv
// Result queue of the timer bank: two entries between executor and the
// result port. Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptb_resq import ptb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  res_t      wdata,
	output logic      wfull,
	input  wire logic rd,
	output logic      rempty,
	output res_t      rdata
);
	res_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign wfull  = (cnt_q == 2'd2);
	assign rempty = (cnt_q == 2'd0);
	assign rdata  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !wfull) begin
				ent_q[wr_q] <= wdata;
				wr_q        <= !wr_q;
			end
			if (rd && !rempty)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'((wr && !wfull) ? 1 : 0) - 2'((rd && !rempty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ptb_exec.sv
// Back end of the timer bank: sequencer that carries out commands and tick
// scans over the per-slot flags and the count RAM. Depends on ptb_pkg, ptb_ram.
`timescale 1ns / 1ps
`default_nettype none
module ptb_exec import ptb_pkg::*; #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	input  wire logic res_full,
	output logic      res_push,
	output res_t      res
);
	localparam int IW   = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
	localparam int CNTW = $clog2(NUM_TIMERS + 1);
	localparam int CW   = COUNT_WIDTH;
	localparam logic [CW-1:0] CMAX = '1;

	typedef struct packed {
		logic [CW-1:0] target;
		logic [CW-1:0] banked;
		logic [CW-1:0] run;
	} row_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CEX, S_CRSP, S_SCAN, S_TRD, S_TEX, S_PUSH
	} state_t;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? CMAX : s[CW-1:0];
	endfunction

	function automatic logic [31:0] clip32(input logic [CW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	function automatic logic [CW-1:0] sat_dur(input logic [31:0] d);
		return (64'(d) > 64'(CMAX)) ? CMAX : CW'(d);
	endfunction

	state_t          state_q;
	cmd_t            cmd_q;
	logic [IW-1:0]   idx_q;
	logic [CNTW-1:0] scan_q;
	logic [NUM_TIMERS-1:0] valid_q, run_q, done_q, sent_q, nfy_q, afree_q;
	logic [CW-1:0]   el_q, tgt_q, run1_q;
	res_t            res_q, held_q;
	logic            held_v_q, ret_scan_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	row_t            ram_wdata, rd, new_row;
	logic [3*CW-1:0] ram_rdata;

	logic            free_found;
	logic [IW-1:0]   free_idx, slot_in, scan_idx;
	logic            present_in, active, run_old, done_old;
	logic [CW-1:0]   sumbr, sum_t, el_c;
	logic            cex_ok, new_run, new_done, expire, fire, drop_slot;
	res_t            ev, idle_res, held_fin;
	state_t          idle_next;

	assign rd       = row_t'(ram_rdata);
	assign slot_in  = IW'(cmd.slot);
	assign scan_idx = IW'(scan_q);
	assign present_in = (32'(cmd.slot) < NUM_TIMERS) && valid_q[slot_in];
	assign active   = valid_q[scan_idx] && run_q[scan_idx] && !done_q[scan_idx];
	assign run_old  = run_q[idx_q];
	assign done_old = done_q[idx_q];
	assign sumbr    = sat_add(rd.banked, rd.run);
	assign sum_t    = sat_add(rd.banked, run1_q);
	assign expire   = (sum_t >= rd.target);
	assign fire     = expire && !sent_q[scan_idx] && nfy_q[scan_idx];
	assign drop_slot = fire && afree_q[scan_idx];
	assign ev = '{kind: 1'b1, ok: 1'b1, timer_index: 4'(scan_idx), exists: 1'b1,
		running: 1'b0, finished: 1'b1, elapsed: clip32(sum_t), remaining: 32'd0,
		last: 1'b0};

	// Final event of a tick carries last.
	always_comb begin
		held_fin      = held_q;
		held_fin.last = 1'b1;
	end

	// Lowest free slot for an allocation.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// Response and next state for a command taken in idle.
	always_comb begin
		idle_res  = '{kind: 1'b0, ok: 1'b0, timer_index: 4'd0,
			exists: 1'b0, running: 1'b0, finished: 1'b0,
			elapsed: 32'd0, remaining: 32'd0, last: 1'b1};
		idle_next = S_PUSH;
		unique case (cmd.cls)
			C_TICK: idle_next = S_SCAN;
			C_ADD: begin
				if (free_found) begin
					idle_res.ok          = 1'b1;
					idle_res.timer_index = 4'(free_idx);
					idle_res.exists      = 1'b1;
					idle_res.remaining   = clip32(sat_dur(cmd.duration));
				end
			end
			C_CLEAR: idle_res.ok = 1'b1;
			C_SLOT: begin
				idle_res.timer_index = cmd.slot;
				if (present_in)
					idle_next = S_CEX;
			end
			default: ;
		endcase
	end

	// Slot command: next counts, flags and elapsed.
	always_comb begin
		new_row  = rd;
		cex_ok   = 1'b1;
		new_run  = run_old;
		new_done = done_old;
		unique case (cmd_q.func) inside
			FN_START, FN_RESET: begin
				new_row  = '{target: rd.target, banked: '0, run: '0};
				new_run  = (cmd_q.func == FN_START);
				new_done = 1'b0;
			end
			FN_STOP: begin
				new_row.run = '0;
				new_run     = 1'b0;
			end
			FN_PAUSE: begin
				cex_ok = run_old;
				if (run_old) begin
					new_row.banked = sumbr;
					new_row.run    = '0;
					new_run        = 1'b0;
				end
			end
			FN_RESUME: begin
				cex_ok = !run_old && !done_old;
				if (cex_ok) begin
					new_row.run = '0;
					new_run     = 1'b1;
				end
			end
			FN_SET_DUR: new_row.target = sat_dur(cmd_q.duration);
			default: ;
		endcase
		if (cmd_q.func == FN_START || cmd_q.func == FN_RESET || cmd_q.func == FN_REMOVE)
			el_c = '0;
		else if (run_old && cmd_q.func != FN_STOP)
			el_c = sumbr;
		else
			el_c = rd.banked;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = new_row;
		ram_raddr = (state_q == S_IDLE) ? slot_in : scan_idx;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.cls == C_ADD && free_found) begin
					ram_we    = 1'b1;
					ram_waddr = free_idx;
					ram_wdata = '{target: sat_dur(cmd.duration), banked: '0, run: '0};
				end
			end
			S_CEX: ram_we = 1'b1;
			S_TEX: begin
				ram_we    = 1'b1;
				ram_waddr = scan_idx;
				ram_wdata = expire ? '{target: rd.target, banked: sum_t, run: '0}
					: '{target: rd.target, banked: rd.banked, run: run1_q};
			end
			default: ;
		endcase
	end

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign res_push = (state_q == S_PUSH) && !res_full;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			run_q      <= '0;
			done_q     <= '0;
			sent_q     <= '0;
			nfy_q      <= '0;
			afree_q    <= '0;
			held_v_q   <= 1'b0;
			ret_scan_q <= 1'b0;
			scan_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						idx_q      <= slot_in;
						ret_scan_q <= 1'b0;
						res_q      <= idle_res;
						state_q    <= idle_next;
						unique case (cmd.cls)
							C_TICK: scan_q <= '0;
							C_ADD: begin
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									run_q[free_idx]   <= 1'b0;
									done_q[free_idx]  <= 1'b0;
									sent_q[free_idx]  <= 1'b0;
									nfy_q[free_idx]   <= cmd.notify;
									afree_q[free_idx] <= cmd.self_remove;
								end
							end
							C_CLEAR: begin
								valid_q <= '0;
								run_q   <= '0;
								done_q  <= '0;
								sent_q  <= '0;
								nfy_q   <= '0;
								afree_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_CEX: begin
					res_q.ok <= cex_ok;
					el_q     <= el_c;
					tgt_q    <= (cmd_q.func == FN_REMOVE) ? '0 : new_row.target;
					if (cmd_q.func == FN_REMOVE) begin
						valid_q[idx_q] <= 1'b0;
						run_q[idx_q]   <= 1'b0;
						done_q[idx_q]  <= 1'b0;
						sent_q[idx_q]  <= 1'b0;
						nfy_q[idx_q]   <= 1'b0;
						afree_q[idx_q] <= 1'b0;
					end else begin
						run_q[idx_q]   <= new_run;
						done_q[idx_q]  <= new_done;
						res_q.exists   <= 1'b1;
						res_q.running  <= new_run;
						res_q.finished <= new_done;
						if (cmd_q.func == FN_START || cmd_q.func == FN_RESET)
							sent_q[idx_q] <= 1'b0;
						if (cmd_q.func == FN_SET_NFY)
							nfy_q[idx_q] <= cmd_q.notify;
					end
					state_q <= S_CRSP;
				end
				S_CRSP: begin
					res_q.elapsed   <= clip32(el_q);
					res_q.remaining <= clip32((tgt_q > el_q) ? tgt_q - el_q : '0);
					state_q         <= S_PUSH;
				end
				S_PUSH: begin
					if (!res_full)
						state_q <= ret_scan_q ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (scan_q == CNTW'(NUM_TIMERS)) begin
						if (held_v_q) begin
							res_q      <= held_fin;
							held_v_q   <= 1'b0;
							ret_scan_q <= 1'b0;
							state_q    <= S_PUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (active) begin
						state_q <= S_TRD;
					end else begin
						scan_q <= scan_q + CNTW'(1);
					end
				end
				S_TRD: begin
					run1_q  <= sat_add(rd.run, CW'(1));
					state_q <= S_TEX;
				end
				S_TEX: begin
					scan_q  <= scan_q + CNTW'(1);
					state_q <= (fire && held_v_q) ? S_PUSH : S_SCAN;
					if (expire) begin
						run_q[scan_idx]  <= 1'b0;
						done_q[scan_idx] <= !drop_slot;
					end
					if (fire) begin
						sent_q[scan_idx] <= !drop_slot;
						if (drop_slot) begin
							valid_q[scan_idx] <= 1'b0;
							nfy_q[scan_idx]   <= 1'b0;
							afree_q[scan_idx] <= 1'b0;
						end
						held_q   <= ev;
						held_v_q <= 1'b1;
						if (held_v_q) begin
							res_q      <= held_q;
							ret_scan_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ptb_ram #(
		.WIDTH(3 * CW),
		.DEPTH(NUM_TIMERS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule
`default_nettype wire

// File: rtl/pausable_timer_bank.sv
// Top level of the pausable timer bank: command front end, executor and
// result queue. Depends on ptb_pkg, ptb_front, ptb_exec, ptb_resq.
//
// A bank of NUM_TIMERS tick counters driven by a command stream. Every
// command other than tick answers with one response beat (kind 0, last 1)
// that shows the slot status after the command. A tick walks the slots in
// order: it takes the command, skips each slot that is not running, reads a
// running slot from the count RAM, bumps its run count, compares and writes
// it back, and ends with a closing step; event beats are pushed during the
// scan, and the scan stalls while the result queue is full. Each expiring
// timer with notify set yields one event beat (kind 1), and the last event
// of a tick carries last. A tick with no expiry gives no beat. Slot
// commands on a present slot pass through RAM read, update, response build
// and push; add, clear and rejected commands go from the command take
// straight to push. Counts live in one RAM of NUM_TIMERS rows, so the
// executor handles one command at a time; a two-entry command queue on the
// input and a two-entry result queue on the output let either side stall
// on its own. Counts saturate at 2^COUNT_WIDTH-1 and read out clipped to
// 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module pausable_timer_bank import ptb_pkg::*; #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [3:0]  func,
	input  wire logic [3:0]  slot,
	input  wire logic [31:0] duration,
	input  wire logic        notify,
	input  wire logic        self_remove,
	output logic             empty,
	input  wire logic        pop,
	output logic             kind,
	output logic             ok,
	output logic [3:0]       timer_index,
	output logic             exists,
	output logic             running,
	output logic             finished,
	output logic [31:0]      elapsed,
	output logic [31:0]      remaining,
	output logic             last
);
	cmd_t cmd;
	logic cmd_valid, cmd_pop;
	res_t exec_res, out_res;
	logic res_push, res_full;

	// Classify and hold incoming command beats.
	ptb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.slot       (slot),
		.duration   (duration),
		.notify     (notify),
		.self_remove(self_remove),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// Carry out commands and tick scans.
	ptb_exec #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (exec_res)
	);

	// Hold finished result beats until taken.
	ptb_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (exec_res),
		.wfull (res_full),
		.rd    (pop),
		.rempty(empty),
		.rdata (out_res)
	);

	assign kind        = out_res.kind;
	assign ok          = out_res.ok;
	assign timer_index = out_res.timer_index;
	assign exists      = out_res.exists;
	assign running     = out_res.running;
	assign finished    = out_res.finished;
	assign elapsed     = out_res.elapsed;
	assign remaining   = out_res.remaining;
	assign last        = out_res.last;

	// An expiry event always shows a stopped, finished, existing timer.
	a_event_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (ok && exists && finished && !running && remaining == 32'd0))
		else $error("expiry event with wrong status");

	// A command response is always the final beat of its command.
	a_rsp_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind) |-> last)
		else $error("command response without last");

	// An absent slot reports no counts.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !exists) |-> (elapsed == 32'd0 && remaining == 32'd0 && !running && !finished))
		else $error("absent slot with nonzero status");

	// The executor never pushes into a full result queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overflow");
endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking bench for pausable_timer_bank: drives command beats through
// the push/full side and checks result beats on the empty/pop side against
// a timer bank predictor. Depends on ptb_pkg and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ptb_pkg::*;

	localparam int NT = 16;
	// Function codes above clear are undefined; the block must answer and ignore them.
	localparam logic [3:0] FN_UNDEF_LO = 4'd12;
	localparam logic [3:0] FN_UNDEF_HI = 4'd15;
	localparam int N_RANDOM  = 500;
	localparam int IDLE_LIMIT = 3000;   // well above the receiver hold-off and a tick scan
	localparam int DRAIN_WAIT = 80;     // covers one full tick scan after the last beat

	// Timer bank predictor and queue of expected result beats.
	class timer_bank_sb;
		bit          vld[NT], run[NT], done[NT], sent[NT], nfy[NT], afree[NT];
		logic [31:0] tgt[NT], bank[NT], cur[NT];
		res_t        pending_beats[$];
		int          errors;

		function new();
			clear_all();
		endfunction

		function void free_slot(int i);
			vld[i] = 0; run[i] = 0; done[i] = 0; sent[i] = 0; nfy[i] = 0; afree[i] = 0;
			tgt[i] = '0; bank[i] = '0; cur[i] = '0;
		endfunction

		function void clear_all();
			for (int i = 0; i < NT; i++)
				free_slot(i);
		endfunction

		// Append one expected beat at the tail.
		function void queue_beat(res_t r);
			pending_beats.insert(pending_beats.size(), r);
		endfunction

		function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
			logic [32:0] t;
			t = {1'b0, a} + {1'b0, b};
			return t[32] ? 32'hFFFF_FFFF : t[31:0];
		endfunction

		function res_t status(bit k, bit okv, int idx, bit have, bit lst);
			res_t r;
			logic [31:0] el;
			r = '0;
			r.kind = k;
			r.ok = okv;
			r.timer_index = idx[3:0];
			r.last = lst;
			if (have && vld[idx]) begin
				el = run[idx] ? sat_sum(bank[idx], cur[idx]) : bank[idx];
				r.exists = 1;
				r.running = run[idx];
				r.finished = done[idx];
				r.elapsed = el;
				r.remaining = (tgt[idx] > el) ? tgt[idx] - el : '0;
			end
			return r;
		endfunction

		// Advance the bank by one accepted command beat and queue what it yields.
		function void note_command(logic [3:0] f, logic [3:0] s, logic [31:0] d,
				logic n, logic sr);
			bit here;
			bit okv;
			int cnt;
			here = vld[s];
			okv = 0;
			cnt = 0;
			case (f)
				FN_TICK: begin
					for (int i = 0; i < NT; i++) begin
						if (!vld[i] || !run[i] || done[i])
							continue;
						cur[i] = sat_sum(cur[i], 32'd1);
						if (sat_sum(bank[i], cur[i]) >= tgt[i]) begin
							bank[i] = sat_sum(bank[i], cur[i]);
							cur[i] = '0;
							run[i] = 0;
							done[i] = 1;
							if (!sent[i] && nfy[i]) begin
								sent[i] = 1;
								queue_beat(status(1, 1, i, 1, 0));
								cnt++;
								if (afree[i])
									free_slot(i);
							end
						end
					end
					if (cnt > 0)
						pending_beats[$].last = 1;
					return;
				end
				FN_ADD: begin
					for (int i = 0; i < NT; i++) begin
						if (!vld[i]) begin
							free_slot(i);
							vld[i] = 1; nfy[i] = n; afree[i] = sr; tgt[i] = d;
							queue_beat(status(0, 1, i, 1, 1));
							return;
						end
					end
					queue_beat(status(0, 0, 0, 0, 1));
					return;
				end
				FN_REMOVE: if (here) begin
					free_slot(s);
					okv = 1;
				end
				FN_START, FN_RESET: if (here) begin
					bank[s] = '0; cur[s] = '0; run[s] = (f == FN_START);
					done[s] = 0; sent[s] = 0;
					okv = 1;
				end
				FN_STOP: if (here) begin
					run[s] = 0; cur[s] = '0;
					okv = 1;
				end
				FN_PAUSE: if (here && run[s]) begin
					bank[s] = sat_sum(bank[s], cur[s]); cur[s] = '0; run[s] = 0;
					okv = 1;
				end
				FN_RESUME: if (here && !run[s] && !done[s]) begin
					cur[s] = '0; run[s] = 1;
					okv = 1;
				end
				FN_SET_DUR: if (here) begin
					tgt[s] = d;
					okv = 1;
				end
				FN_SET_NFY: if (here) begin
					nfy[s] = n;
					okv = 1;
				end
				FN_QUERY: okv = here;
				FN_CLEAR: begin
					clear_all();
					queue_beat(status(0, 1, 0, 0, 1));
					return;
				end
				default: begin
					queue_beat(status(0, 0, 0, 0, 1));
					return;
				end
			endcase
			queue_beat(status(0, okv, s, 1, 1));
		endfunction

		task report(string what);
			$display("%0t: result beat error: %s", $realtime, what);
			errors++;
		endtask

		// Compare one popped beat with the oldest expectation.
		task check_result(res_t got);
			res_t e;
			if (pending_beats.size() == 0) begin
				report($sformatf("unexpected beat %p", got));
				return;
			end
			e = pending_beats.pop_front();
			if (got.kind !== e.kind)
				report($sformatf("kind %0d, want %0d", got.kind, e.kind));
			if (got.ok !== e.ok)
				report($sformatf("ok %0d, want %0d", got.ok, e.ok));
			if (got.timer_index !== e.timer_index)
				report($sformatf("timer_index %0d, want %0d", got.timer_index,
					e.timer_index));
			if (got.exists !== e.exists)
				report($sformatf("exists %0d, want %0d", got.exists, e.exists));
			if (got.running !== e.running)
				report($sformatf("running %0d, want %0d", got.running, e.running));
			if (got.finished !== e.finished)
				report($sformatf("finished %0d, want %0d", got.finished, e.finished));
			if (got.elapsed !== e.elapsed)
				report($sformatf("elapsed %0d, want %0d", got.elapsed, e.elapsed));
			if (got.remaining !== e.remaining)
				report($sformatf("remaining %0d, want %0d", got.remaining, e.remaining));
			if (got.last !== e.last)
				report($sformatf("last %0d, want %0d", got.last, e.last));
		endtask
	endclass

	logic        clk, arst_n, push, full, empty, pop;
	logic [3:0]  func, slot, timer_index;
	logic [31:0] duration, elapsed, remaining;
	logic        notify, self_remove, kind, ok, exists, running, finished, last;

	timer_bank_sb sb;
	bit stim_done;
	int beats_popped;
	int idle_cycles;

	pausable_timer_bank DUT (
		.clk, .arst_n, .push, .full, .func, .slot, .duration, .notify,
		.self_remove, .empty, .pop, .kind, .ok, .timer_index, .exists,
		.running, .finished, .elapsed, .remaining, .last
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Offer one command beat after a random gap; hold it until the block takes it.
	task send_cmd(logic [3:0] f, logic [3:0] s, logic [31:0] d, logic n, logic sr);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0)
			gap = 0;    // keep some back-to-back stretches
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		func <= f; slot <= s; duration <= d; notify <= n; self_remove <= sr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_command(f, s, d, n, sr);
	endtask

	function logic [31:0] rand_duration();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 6);
		if (r < 9)
			return $urandom_range(0, 40);
		return $urandom;
	endfunction

	// Weighted command mix: plenty of ticks and adds so timers expire and the bank fills.
	task send_random();
		int r;
		logic [3:0] f;
		r = $urandom_range(0, 99);
		if (r < 32)      f = FN_TICK;
		else if (r < 50) f = FN_ADD;
		else if (r < 52) f = FN_CLEAR;
		else if (r < 54) f = 4'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI));
		else if (r < 64) f = FN_START;
		else             f = 4'($urandom_range(FN_REMOVE, FN_QUERY));
		send_cmd(f, 4'($urandom_range(0, 15)), rand_duration(), 1'($urandom),
			1'($urandom));
	endtask

	// Sender: directed opening, then the random stream with one full drain pause.
	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		func = FN_TICK; slot = '0; duration = '0; notify = 1'b0; self_remove = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(FN_ADD, 4'd9, 32'd0, 1, 0);           // zero duration, slot 0
		send_cmd(FN_ADD, 4'd0, 32'hFFFF_FFFF, 1, 1);   // longest duration
		send_cmd(FN_ADD, 4'd0, 32'd2, 1, 1);           // self-removing
		send_cmd(FN_START, 4'd0, 32'hFFFF_FFFF, 1, 1);
		send_cmd(FN_START, 4'd2, 32'd0, 0, 0);
		send_cmd(FN_START, 4'd1, 32'd0, 0, 0);
		send_cmd(FN_TICK, 4'd15, 32'd0, 0, 0);         // slot 0 expires at once
		send_cmd(FN_PAUSE, 4'd2, 32'd0, 0, 0);
		send_cmd(FN_PAUSE, 4'd2, 32'd0, 0, 0);         // pause when not running
		send_cmd(FN_RESUME, 4'd2, 32'd0, 0, 0);
		send_cmd(FN_RESUME, 4'd0, 32'd0, 0, 0);        // resume of finished timer
		send_cmd(FN_TICK, 4'd0, 32'd0, 0, 0);          // slot 2 expires and frees
		send_cmd(FN_QUERY, 4'd2, 32'd0, 0, 0);         // now missing
		send_cmd(FN_SET_DUR, 4'd1, 32'd5, 0, 0);
		send_cmd(FN_SET_NFY, 4'd1, 32'd0, 0, 0);
		send_cmd(FN_TICK, 4'd0, 32'd0, 0, 0);
		send_cmd(FN_STOP, 4'd1, 32'd0, 0, 0);
		send_cmd(FN_RESET, 4'd0, 32'd0, 0, 0);
		send_cmd(FN_QUERY, 4'd0, 32'd0, 0, 0);
		send_cmd(FN_REMOVE, 4'd0, 32'd0, 0, 0);
		send_cmd(FN_REMOVE, 4'd15, 32'd0, 0, 0);       // never allocated
		send_cmd(FN_UNDEF_LO, 4'd3, 32'hFFFF_FFFF, 1, 1);
		send_cmd(FN_UNDEF_HI, 4'd15, 32'd0, 0, 0);
		send_cmd(FN_CLEAR, 4'd7, 32'd0, 0, 0);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == 300) begin
				push <= 1'b0;
				do
					@(posedge clk);
				while (sb.pending_beats.size() != 0);
			end
			send_random();
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random pop gaps, plus one long hold-off that backs the block up.
	initial begin
		res_t got;
		int w;
		bit held;
		pop = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0)
				w = 0;
			if (!held && beats_popped == 120) begin
				held = 1'b1;
				w = 400;
			end
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got.kind = kind; got.ok = ok; got.timer_index = timer_index;
			got.exists = exists; got.running = running; got.finished = finished;
			got.elapsed = elapsed; got.remaining = remaining; got.last = last;
			sb.check_result(got);
			beats_popped++;
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Drain: wait for every expected beat, then one tick scan more for strays.
	initial begin
		wait (stim_done);
		while (sb.pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending_beats.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
